@@ hdl/pptt_pkg.sv @@
// ============================================================================
// pptt_pkg
// Shared types and constants for the pending probe table with timeout.
// ============================================================================
package pptt_pkg;

    localparam int DATA_BITS     = 64;
    localparam int OCC_BITS      = 5;
    localparam int TIME_BITS     = 32;
    localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = 32'd30;

    typedef enum logic [1:0] {
        FUNC_MAKE  = 2'd0,
        FUNC_MATCH = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_MATCHED  = 2'd3
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [DATA_BITS-1:0]   target;
        logic [DATA_BITS-1:0]   conn;
        logic [OCC_BITS-1:0]    occupancy;
    } result_t;

endpackage

@@ hdl/pending_probe_table_with_timeout.sv @@
// ============================================================================
// pending_probe_table_with_timeout
// Ordered table of outstanding probes with token match and tick-based reaping.
// ============================================================================
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: func; tdata: token, target_id, conn_info
//  m_*      out  m_tvalid/m_tready  tuser: status; tdata: matched_target,
//                                   matched_conn, occupancy
//  cfg_*    in   cfg_we             cfg_wdata: max_timeout
//
//  Make and clear pass from accept through the exec state to the done state.
//  Match and tick add a scan of the n entries held: one entry store read per
//  cycle, set by the single read port of the store.
//  Reset empties the table through the held count; the store itself is not
//  cleared. The result register lets the next item be taken while a result
//  waits on m_tready; a held result stalls only the finish.
//
module pending_probe_table_with_timeout #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TOKEN_BITS    = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // token[63:0], target_id[127:64], conn_info[191:128]
    input  logic [1:0]   s_tuser,   // func[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // matched_target[63:0], matched_conn[127:64],
                                    // occupancy[132:128], zero[135:133]
    output logic [1:0]   m_tuser,   // status[1:0]
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);
    import pptt_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int EW = TOKEN_BITS + 2 * DATA_BITS + TIME_BITS;

    logic           mem_wr_en;
    logic [IW-1:0]  mem_wr_addr;
    logic [EW-1:0]  mem_wr_data;
    logic           mem_rd_en;
    logic [IW-1:0]  mem_rd_addr;
    logic [EW-1:0]  mem_rd_data;

    logic           res_valid;
    logic           res_ready;
    result_t        res;

    logic           out_valid_reg, out_valid_next;
    result_t        out_reg;

    pptt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    pptt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TOKEN_BITS    (TOKEN_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (func_t'(s_tuser)),
        .in_token    (s_tdata[TOKEN_BITS-1:0]),
        .in_target   (s_tdata[127:64]),
        .in_conn     (s_tdata[191:128]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // load the result register when it is empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.occupancy, out_reg.conn, out_reg.target};

endmodule

@@ hdl/pptt_mem.sv @@
// ============================================================================
// pptt_mem
// Entry store: one write port, one read port with registered read data.
// ============================================================================
module pptt_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 224
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/pptt_ctrl.sv @@
// ============================================================================
// pptt_ctrl
// Sequencer: make, clear, and a compacting read-modify-write scan of the
// entry store for match and tick.
// ============================================================================
module pptt_ctrl #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TOKEN_BITS    = 64,
    parameter int IW            = $clog2(TABLE_ENTRIES),
    parameter int EW            = TOKEN_BITS + 2 * pptt_pkg::DATA_BITS + pptt_pkg::TIME_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pptt_pkg::TIME_BITS-1:0]     cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  pptt_pkg::func_t                    in_func,
    input  logic [TOKEN_BITS-1:0]              in_token,
    input  logic [pptt_pkg::DATA_BITS-1:0]     in_target,
    input  logic [pptt_pkg::DATA_BITS-1:0]     in_conn,
    output logic                               res_valid,
    input  logic                               res_ready,
    output pptt_pkg::result_t                  res,
    output logic                               mem_wr_en,
    output logic [IW-1:0]                      mem_wr_addr,
    output logic [EW-1:0]                      mem_wr_data,
    output logic                               mem_rd_en,
    output logic [IW-1:0]                      mem_rd_addr,
    input  logic [EW-1:0]                      mem_rd_data
);
    import pptt_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    func_t                  func_reg, func_next;
    logic [TOKEN_BITS-1:0]  token_reg, token_next;
    logic [DATA_BITS-1:0]   target_reg, target_next;
    logic [DATA_BITS-1:0]   conn_reg, conn_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [CW-1:0]          rd_reg, rd_next;
    logic [CW-1:0]          wr_reg, wr_next;
    logic                   pend_reg, pend_next;
    logic                   found_reg, found_next;
    logic [TIME_BITS-1:0]   tick_reg, tick_next;
    logic [TIME_BITS-1:0]   timeout_reg, timeout_next;
    status_t                stat_reg, stat_next;
    logic [DATA_BITS-1:0]   mt_reg, mt_next;
    logic [DATA_BITS-1:0]   mc_reg, mc_next;

    logic                   accept;
    logic                   rd_issue;
    logic                   drop;
    logic [TOKEN_BITS-1:0]  e_token;
    logic [DATA_BITS-1:0]   e_target;
    logic [DATA_BITS-1:0]   e_conn;
    logic [TIME_BITS-1:0]   e_stamp;
    logic [TIME_BITS-1:0]   age;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_DONE);

    assign res.status    = stat_reg;
    assign res.target    = mt_reg;
    assign res.conn      = mc_reg;
    assign res.occupancy = OCC_BITS'(n_reg);

    assign {e_stamp, e_conn, e_target, e_token} = mem_rd_data;
    assign age      = tick_reg - e_stamp;
    assign rd_issue = (state_reg == ST_SCAN) && (rd_reg < n_reg);
    assign mem_rd_en   = rd_issue;
    assign mem_rd_addr = rd_reg[IW-1:0];

    always_comb
    begin
        if (func_reg == FUNC_TICK)
        begin
            drop = (age > timeout_reg);
        end
        else
        begin
            drop = !found_reg && (e_token == token_reg);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        token_next   = token_reg;
        target_next  = target_reg;
        conn_next    = conn_reg;
        n_next       = n_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        pend_next    = pend_reg;
        found_next   = found_reg;
        tick_next    = tick_reg;
        timeout_next = cfg_we ? cfg_wdata : timeout_reg;
        stat_next    = stat_reg;
        mt_next      = mt_reg;
        mc_next      = mc_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = wr_reg[IW-1:0];
        mem_wr_data  = mem_rd_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next   = in_func;
                    token_next  = in_token;
                    target_next = in_target;
                    conn_next   = in_conn;
                    rd_next     = '0;
                    wr_next     = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    mt_next     = '0;
                    mc_next     = '0;
                    // ages are taken against the advanced count
                    if (in_func == FUNC_TICK)
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (func_reg)
                    FUNC_MAKE:
                    begin
                        if (n_reg == CW'(TABLE_ENTRIES))
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            stat_next   = STAT_DONE;
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = n_reg[IW-1:0];
                            mem_wr_data = {tick_reg, conn_reg, target_reg, token_reg};
                            n_next      = n_reg + CW'(1);
                        end
                        state_next = ST_DONE;
                    end
                    FUNC_CLEAR:
                    begin
                        stat_next  = STAT_DONE;
                        n_next     = '0;
                        state_next = ST_DONE;
                    end
                    FUNC_MATCH:
                    begin
                        stat_next  = STAT_NOTFOUND;
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        stat_next  = STAT_DONE;
                        state_next = ST_SCAN;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (rd_issue)
                begin
                    rd_next   = rd_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // compact: kept entries move down to the write pointer
                if (pend_reg)
                begin
                    if (drop)
                    begin
                        if (func_reg == FUNC_MATCH)
                        begin
                            found_next = 1'b1;
                            stat_next  = STAT_MATCHED;
                            mt_next    = e_target;
                            mc_next    = e_conn;
                        end
                    end
                    else
                    begin
                        mem_wr_en = 1'b1;
                        wr_next   = wr_reg + CW'(1);
                    end
                end
                if (!rd_issue && !pend_reg)
                begin
                    n_next     = wr_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            rd_reg      <= '0;
            wr_reg      <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            tick_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            rd_reg      <= rd_next;
            wr_reg      <= wr_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            tick_reg    <= tick_next;
            timeout_reg <= timeout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        token_reg  <= token_next;
        target_reg <= target_next;
        conn_reg   <= conn_next;
        stat_reg   <= stat_next;
        mt_reg     <= mt_next;
        mc_reg     <= mc_next;
    end

    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && mem_wr_en) |-> (wr_reg < rd_reg))
        else $error("scan writes an entry not yet read");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(TABLE_ENTRIES))
        else $error("occupancy beyond table size");

    a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !rd_issue && !pend_reg && func_reg == FUNC_MATCH)
        |-> ((wr_reg + CW'(found_reg)) == n_reg))
        else $error("match scan lost or duplicated entries");

    a_tick_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tick_reg) |-> $past(accept && in_func == FUNC_TICK))
        else $error("tick count moved without a tick item");

endmodule
